// File: sv/abps_pkg.sv
// Shared types, constants and the Adams-Bashforth weight table for the path stepper.
// No dependencies; every other file imports this package.
package abps_pkg;

  localparam int DIGIT_BITS     = 8;
  localparam int REM_W          = 11;
  localparam int WEIGHT_W       = 13;
  localparam int COEF_HALF      = 360;
  localparam int MAX_STEP_RESET = 42950;

  localparam logic [REM_W-1:0] CLAMP_DEN = 11'd100;
  localparam logic [REM_W-1:0] COEF_DEN  = 11'd720;

  localparam logic REG_MAX_STEP = 1'b0;
  localparam logic REG_PERIODIC = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FINAL     = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic {
    SRC_WEIGHT = 1'b0,
    SRC_STEP   = 1'b1
  } msrc_t;

  typedef struct packed {
    logic       accept;
    logic       div_load_m;
    logic       div_load_b;
    logic       div_run;
    logic       clamp;
    logic       hist_wr0;
    logic       acc_clr;
    logic       mul_issue;
    msrc_t      mul_src;
    logic [2:0] hist_idx;
    logic [1:0] comp;
    logic [1:0] piece;
    logic       vnew_cap;
    logic       inc_done;
    logic       finish;
  } dp_cmd_t;

  typedef struct packed {
    logic       hmag_zero;
    logic [2:0] order;
    logic       out_free;
  } dp_stat_t;

  // row = order - 1, col = history slot (0 newest)
  function automatic logic signed [WEIGHT_W-1:0] ab_weight(input logic [2:0] row,
                                                            input logic [2:0] col);
    logic signed [WEIGHT_W-1:0] w;
    w = '0;
    case ({row, col})
      6'o00: w = 13'sd720;
      6'o10: w = 13'sd1080;
      6'o11: w = -13'sd360;
      6'o20: w = 13'sd1380;
      6'o21: w = -13'sd960;
      6'o22: w = 13'sd300;
      6'o30: w = 13'sd1650;
      6'o31: w = -13'sd1770;
      6'o32: w = 13'sd1110;
      6'o33: w = -13'sd270;
      6'o40: w = 13'sd1901;
      6'o41: w = -13'sd2774;
      6'o42: w = 13'sd2616;
      6'o43: w = -13'sd1274;
      6'o44: w = 13'sd251;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: sv/abps_cfg.sv
// APB-style register file: max_step and periodic_mode.
// Depends on abps_pkg.
module abps_cfg #(
  parameter int WORD_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  output logic [WORD_BITS-2:0] max_step,
  output logic                 periodic
);
  import abps_pkg::*;

  logic [WORD_BITS-2:0] max_step_r;
  logic                 periodic_r;
  logic                 wr;

  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite && pready;
  assign max_step = max_step_r;
  assign periodic = periodic_r;

  always_comb begin
    case (paddr[3])
      REG_MAX_STEP: prdata = 64'(max_step_r);
      REG_PERIODIC: prdata = 64'(periodic_r);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_step_r <= (WORD_BITS-1)'(MAX_STEP_RESET);
      periodic_r <= 1'b0;
    end else if (wr) begin
      case (paddr[3])
        REG_MAX_STEP: max_step_r <= pwdata[WORD_BITS-2:0];
        REG_PERIODIC: periodic_r <= pwdata[0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/abps_ctrl.sv
// Controller FSM: sequences divide, clamp, weighted sum, step products and writeback.
// Depends on abps_pkg; drives the datapath through dp_cmd_t.
module abps_ctrl #(
  parameter int WORD_BITS = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  abps_pkg::op_t      in_op,
  output logic               in_tready,
  input  abps_pkg::dp_stat_t stat,
  output abps_pkg::dp_cmd_t  cmd
);
  import abps_pkg::*;

  localparam int DIV_STEPS = (WORD_BITS + 14 + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_MDIV   = 13'b0000000000010,
    S_CLAMP  = 13'b0000000000100,
    S_CHK    = 13'b0000000001000,
    S_WMUL   = 13'b0000000010000,
    S_WDRAIN = 13'b0000000100000,
    S_BLOAD  = 13'b0000001000000,
    S_BDIV   = 13'b0000010000000,
    S_VCAP   = 13'b0000100000000,
    S_HMUL   = 13'b0001000000000,
    S_HDRAIN = 13'b0010000000000,
    S_INC    = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       i_r, i_nxt;
  logic [1:0]       c_r, c_nxt;
  logic [1:0]       p_r, p_nxt;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    i_nxt        = i_r;
    c_nxt        = c_r;
    p_nxt        = p_r;
    in_tready    = 1'b0;
    cmd          = '0;
    cmd.hist_idx = i_r;
    cmd.comp     = c_r;
    cmd.piece    = p_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (in_op == OP_STEP) begin
            cmd.div_load_m = 1'b1;
            cnt_nxt        = '0;
            state_nxt      = S_MDIV;
          end
        end
      end
      S_MDIV, S_BDIV: begin
        cmd.div_run = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == S_MDIV) ? S_CLAMP : S_VCAP;
        end
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.hmag_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.hist_wr0 = 1'b1;
          cmd.acc_clr  = 1'b1;
          i_nxt        = '0;
          c_nxt        = '0;
          p_nxt        = '0;
          state_nxt    = S_WMUL;
        end
      end
      S_WMUL: begin
        cmd.mul_issue = 1'b1;
        cmd.mul_src   = SRC_WEIGHT;
        p_nxt         = p_r + 1'b1;
        if (p_r == 2'd3) begin
          if (i_r == 3'(stat.order - 3'd1)) state_nxt = S_WDRAIN;
          else i_nxt = i_r + 1'b1;
        end
      end
      S_WDRAIN: state_nxt = S_BLOAD;
      S_BLOAD: begin
        cmd.div_load_b = 1'b1;
        cnt_nxt        = '0;
        state_nxt      = S_BDIV;
      end
      S_VCAP: begin
        cmd.vnew_cap = 1'b1;
        cmd.acc_clr  = 1'b1;
        p_nxt        = '0;
        state_nxt    = S_HMUL;
      end
      S_HMUL: begin
        cmd.mul_issue = 1'b1;
        cmd.mul_src   = SRC_STEP;
        p_nxt         = p_r + 1'b1;
        if (p_r == 2'd3) state_nxt = S_HDRAIN;
      end
      S_HDRAIN: state_nxt = S_INC;
      S_INC: begin
        cmd.inc_done = 1'b1;
        if (c_r == 2'd2) begin
          state_nxt = S_FIN;
        end else begin
          c_nxt       = c_r + 1'b1;
          i_nxt       = '0;
          p_nxt       = '0;
          cmd.acc_clr = 1'b1;
          state_nxt   = S_WMUL;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      i_r     <= '0;
      c_r     <= '0;
      p_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      i_r     <= i_nxt;
      c_r     <= c_nxt;
      p_r     <= p_nxt;
    end
  end

`ifndef SYNTH
  a_step_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_op == OP_STEP) |=> state_r == S_MDIV)
    else $error("step beat did not start the clamp divide");
  a_start_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_op == OP_START) |=> state_r == S_IDLE)
    else $error("start beat left idle");
  a_hist_idx_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_issue && cmd.mul_src == SRC_WEIGHT |-> i_r < stat.order)
    else $error("history read beyond current order");
`endif

endmodule

// File: sv/abps_dpath.sv
// Datapath: state, history, shared multiplier with accumulator, constant divider,
// clamp logic and the output register. Depends on abps_pkg.
module abps_dpath #(
  parameter int HISTORY_DEPTH = 5,
  parameter int WORD_BITS     = 48,
  parameter int FRACTION_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  abps_pkg::dp_cmd_t      cmd,
  output abps_pkg::dp_stat_t     stat,
  input  abps_pkg::op_t          in_op,
  input  logic [8*WORD_BITS-1:0] in_data,
  input  logic [WORD_BITS-2:0]   max_step,
  input  logic                   periodic,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_status,
  output logic [8*WORD_BITS-1:0] out_data
);
  import abps_pkg::*;

  localparam int W         = WORD_BITS;
  localparam int HALF      = (W + 1) / 2;
  localparam int OP_W      = 2 * HALF;
  localparam int ACC_W     = 2 * OP_W + 2;
  localparam int DIV_STEPS = (W + 14 + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int DIV_W     = DIV_STEPS * DIGIT_BITS;
  localparam int IDX_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W-1:0] sat_word(input logic neg, input logic [ACC_W-1:0] mag);
    logic ovf;
    ovf = (|mag[ACC_W-1:W]) || (mag[W-1] && (!neg || (|mag[W-2:0])));
    if (ovf) return neg ? WMIN : WMAX;
    return neg ? W'(-mag[W-1:0]) : mag[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    return v[W-1] ? W'(-v) : v;
  endfunction

  // architectural state
  logic [W-1:0] pos_r [3];
  logic [W-1:0] now_r;
  logic [2:0]   order_r;
  logic [W-1:0] hist_r [HISTORY_DEPTH][3];

  // per-step working registers
  logic [W-1:0]       vel_r [3];
  logic [W-1:0]       end_r;
  logic [DIV_W-1:0]   div_q_r;
  logic [REM_W-1:0]   div_rem_r;
  logic               div_720_r;
  logic               blend_neg_r;
  logic               fwd_r, last_r;
  logic [W-1:0]       hmag_r;
  logic [2*HALF-1:0]  pp_r;
  logic [1:0]         pp_sh_r;
  logic               pp_neg_r, pp_v_r;
  logic [ACC_W-1:0]   acc_r;
  logic [W-1:0]       vnew_r;
  logic [W-1:0]       to_r [3];
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [8*W-1:0]     out_data_r;

  // divider step
  logic [DIV_W-1:0] div_q_nxt;
  logic [REM_W-1:0] div_rem_nxt, div_d;
  always_comb begin
    div_q_nxt   = div_q_r;
    div_rem_nxt = div_rem_r;
    div_d       = div_720_r ? COEF_DEN : CLAMP_DEN;
    for (int k = 0; k < DIGIT_BITS; k++) begin
      div_rem_nxt = {div_rem_nxt[REM_W-2:0], div_q_nxt[DIV_W-1]};
      div_q_nxt   = {div_q_nxt[DIV_W-2:0], 1'b0};
      if (div_rem_nxt >= div_d) begin
        div_rem_nxt  = div_rem_nxt - div_d;
        div_q_nxt[0] = 1'b1;
      end
    end
  end

  // clamp
  logic         fwd;
  logic [W:0]   diff, m101;
  logic [W-1:0] rem, hmag;
  logic         last;
  always_comb begin
    fwd  = $signed(end_r) > $signed(now_r);
    diff = fwd ? ({end_r[W-1], end_r} - {now_r[W-1], now_r})
               : ({now_r[W-1], now_r} - {end_r[W-1], end_r});
    rem  = diff[W-1:0];
    m101 = (W+1)'(max_step) + (W+1)'(div_q_r);
    last = m101 > {1'b0, rem};
    hmag = last ? rem : W'(max_step);
  end

  // multiplier operands
  logic [W-1:0]               hv;
  logic signed [WEIGHT_W-1:0] wt;
  logic [OP_W-1:0]            a_op, b_op;
  logic [HALF-1:0]            a_pc, b_pc;
  logic                       op_neg;
  always_comb begin
    hv = hist_r[IDX_W'(cmd.hist_idx)][cmd.comp];
    wt = ab_weight(3'(order_r - 3'd1), cmd.hist_idx);
    if (cmd.mul_src == SRC_WEIGHT) begin
      a_op   = OP_W'(mag_of(hv));
      b_op   = OP_W'(wt[WEIGHT_W-1] ? -wt : wt);
      op_neg = hv[W-1] ^ wt[WEIGHT_W-1];
    end else begin
      a_op   = OP_W'(hmag_r);
      b_op   = OP_W'(mag_of(vnew_r));
      op_neg = 1'b0;
    end
    a_pc = cmd.piece[0] ? a_op[OP_W-1:HALF] : a_op[HALF-1:0];
    b_pc = cmd.piece[1] ? b_op[OP_W-1:HALF] : b_op[HALF-1:0];
  end

  logic [ACC_W-1:0] term;
  always_comb begin
    case (pp_sh_r)
      2'd0:    term = ACC_W'(pp_r);
      2'd1:    term = ACC_W'(pp_r) << HALF;
      default: term = ACC_W'(pp_r) << (2 * HALF);
    endcase
  end

  logic [ACC_W-1:0] acc_mag, inc_sum;
  logic [W-1:0]     inc;
  logic [W-1:0]     to_tick, now_after;
  logic [2:0]       order_nxt;
  always_comb begin
    acc_mag   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : acc_r;
    inc_sum   = (acc_r + (ACC_W'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    inc       = sat_word(!fwd_r ^ vnew_r[W-1], inc_sum);
    to_tick   = last_r ? end_r : (fwd_r ? now_r + hmag_r : now_r - hmag_r);
    now_after = (last_r && periodic && end_r != WMAX) ? end_r + 1'b1 : to_tick;
    order_nxt = (order_r < 3'(HISTORY_DEPTH)) ? order_r + 3'd1 : order_r;
  end

  assign stat.hmag_zero = (hmag_r == '0);
  assign stat.order     = order_r;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) pos_r[c] <= '0;
      now_r       <= '0;
      order_r     <= 3'd1;
      out_valid_r <= 1'b0;
      pp_v_r      <= 1'b0;
    end else begin
      pp_v_r <= cmd.mul_issue;
      if (cmd.accept && in_op == OP_START) begin
        for (int c = 0; c < 3; c++) pos_r[c] <= in_data[c*W +: W];
        now_r   <= in_data[3*W +: W];
        order_r <= 3'd1;
      end
      if (cmd.finish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.finish && !stat.hmag_zero) begin
        for (int c = 0; c < 3; c++) pos_r[c] <= to_r[c];
        now_r   <= now_after;
        order_r <= order_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int c = 0; c < 3; c++) vel_r[c] <= in_data[(4+c)*W +: W];
      end_r <= in_data[7*W +: W];
    end
    if (cmd.div_load_m) begin
      div_q_r   <= DIV_W'(max_step);
      div_rem_r <= '0;
      div_720_r <= 1'b0;
    end else if (cmd.div_load_b) begin
      div_q_r     <= DIV_W'(acc_mag) + DIV_W'(COEF_HALF);
      div_rem_r   <= '0;
      div_720_r   <= 1'b1;
      blend_neg_r <= acc_r[ACC_W-1];
    end else if (cmd.div_run) begin
      div_q_r   <= div_q_nxt;
      div_rem_r <= div_rem_nxt;
    end
    if (cmd.clamp) begin
      fwd_r  <= fwd;
      last_r <= last;
      hmag_r <= hmag;
    end
    if (cmd.hist_wr0) begin
      for (int c = 0; c < 3; c++) hist_r[0][c] <= vel_r[c];
    end
    if (cmd.finish && !stat.hmag_zero) begin
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        if (3'(i) < order_nxt) begin
          for (int c = 0; c < 3; c++) hist_r[i][c] <= hist_r[i-1][c];
        end
      end
    end
    if (cmd.mul_issue) begin
      pp_r     <= a_pc * b_pc;
      pp_sh_r  <= 2'(cmd.piece[0]) + 2'(cmd.piece[1]);
      pp_neg_r <= op_neg;
    end
    if (cmd.acc_clr) acc_r <= '0;
    else if (pp_v_r) acc_r <= pp_neg_r ? acc_r - term : acc_r + term;
    if (cmd.vnew_cap) vnew_r <= sat_word(blend_neg_r, ACC_W'(div_q_r));
    if (cmd.inc_done) to_r[cmd.comp] <= sat_add(pos_r[cmd.comp], inc);
    if (cmd.finish) begin
      for (int c = 0; c < 3; c++) out_data_r[c*W +: W] <= pos_r[c];
      out_data_r[6*W +: W] <= now_r;
      if (stat.hmag_zero) begin
        out_status_r <= ST_UNDERFLOW;
        for (int c = 0; c < 3; c++) out_data_r[(3+c)*W +: W] <= pos_r[c];
        out_data_r[7*W +: W] <= now_r;
      end else begin
        out_status_r <= last_r ? ST_FINAL : ST_OK;
        for (int c = 0; c < 3; c++) out_data_r[(3+c)*W +: W] <= to_r[c];
        out_data_r[7*W +: W] <= to_tick;
      end
    end
  end

`ifndef SYNTH
  a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
    order_r >= 3'd1 && order_r <= 3'(HISTORY_DEPTH))
    else $error("order out of range");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while pending");
  a_clr_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_clr |-> !pp_v_r)
    else $error("accumulator cleared with a product in flight");
`endif

endmodule

// File: sv/adams_bashforth_path_stepper.sv
// Top level of the Adams-Bashforth path stepper: config registers, controller, datapath.
// Depends on abps_pkg, abps_cfg, abps_ctrl, abps_dpath.
//
//   channel | direction | beat contents
//   in_     | slave     | start point and time, or velocity and end time
//   out_    | master    | status, from/to point and from/to time (steps only)
//   cfg     | APB       | max_step @0x0, periodic_mode @0x8
//
// A step beat runs the clamp divide, then per axis x,y,z the weighted sum, the blend divide and
// the step products; its length is set by the shared multiplier (four partial products per term)
// and the radix-256 divider. An underflowing step goes from the clamp straight to the result.
// Reset is synchronous; no clearing pass.
// A stalled result waits in the output register; the next input beat is taken meanwhile.
module adams_bashforth_path_stepper #(
  parameter int HISTORY_DEPTH = 5,
  parameter int WORD_BITS     = 48,
  parameter int FRACTION_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // start_x, start_y, start_z, start_time, vel_x, vel_y, vel_z, end_time
  input  logic [8*WORD_BITS-1:0] in_tdata,
  // operation
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // from_x, from_y, from_z, to_x, to_y, to_z, from_tick, to_tick
  output logic [8*WORD_BITS-1:0] out_tdata,
  // status
  output logic [1:0]             out_tuser,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);
  import abps_pkg::*;

  logic [WORD_BITS-2:0] max_step;
  logic                 periodic;
  dp_cmd_t              cmd;
  dp_stat_t             stat;
  op_t                  in_op;

  assign in_op = op_t'(in_tuser);

  abps_cfg #(.WORD_BITS(WORD_BITS)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .max_step (max_step),
    .periodic (periodic)
  );

  abps_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_op),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  abps_dpath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_op),
    .in_data    (in_tdata),
    .max_step   (max_step),
    .periodic   (periodic),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_data   (out_tdata)
  );

endmodule

// File: verif/adams_bashforth_path_stepper_tb.sv
// Self-checking testbench for adams_bashforth_path_stepper: directed table, then random
// start/step runs over several max_step and periodic_mode settings. Depends on abps_pkg.
`timescale 1ns / 1ps

module adams_bashforth_path_stepper_tb;
  import abps_pkg::*;

  localparam int WB = 48;
  localparam int WDOG_LIMIT = 40000;
  localparam int STALL_LEN = 3000;
  localparam logic [3:0] ADDR_MAX_STEP = 4'h0;
  localparam logic [3:0] ADDR_PERIODIC = 4'h8;
  localparam logic signed [WB-1:0] W_MAX = {1'b0, {(WB-1){1'b1}}};
  localparam logic signed [WB-1:0] W_MIN = {1'b1, {(WB-1){1'b0}}};
  localparam logic [WB-2:0] STEP_TOP = {(WB-1){1'b1}};

  typedef logic signed [WB-1:0] word_t;

  typedef struct {
    status_t st;
    word_t   f[8];
  } point_pair_t;

  typedef struct {
    op_t     op;
    word_t   a, b, c, d;
    bit      known;
    status_t st;
  } row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [8*WB-1:0] in_tdata = '0;
  logic            in_tuser = 1'b0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [8*WB-1:0] out_tdata;
  logic [1:0]      out_tuser;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [3:0]      paddr = '0;
  logic [63:0]     pwdata = '0;
  logic [63:0]     prdata;
  logic            pready;

  adams_bashforth_path_stepper i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // stepper model state
  word_t       pos[3];
  word_t       now_t;
  word_t       vhist[5][3];
  int          order_q;
  logic [46:0] step_max;
  bit          periodic;
  int          abw[5][5] = '{'{720, 0, 0, 0, 0}, '{1080, -360, 0, 0, 0},
                             '{1380, -960, 300, 0, 0}, '{1650, -1770, 1110, -270, 0},
                             '{1901, -2774, 2616, -1274, 251}};

  point_pair_t pending_pts[$];
  int          errors = 0;
  bit          hold_req = 0;
  int          idle_cycles = 0;

  function automatic word_t sat_mag(bit neg, logic [127:0] m);
    if (!neg && m > 128'(W_MAX)) return W_MAX;
    if (neg && m > (128'(W_MAX) + 1)) return W_MIN;
    return neg ? word_t'(-m[WB-1:0]) : word_t'(m[WB-1:0]);
  endfunction

  function automatic word_t sat_add(word_t a, word_t b);
    logic signed [WB:0] s;
    s = a + b;
    if (s > W_MAX) return W_MAX;
    if (s < W_MIN) return W_MIN;
    return s[WB-1:0];
  endfunction

  function automatic logic [127:0] magn(word_t v);
    logic signed [127:0] vv;
    vv = v;
    return vv < 0 ? -vv : vv;
  endfunction

  function automatic word_t ab_velocity(int o, int c);
    logic signed [127:0] acc;
    logic [127:0] m;
    bit neg;
    acc = 0;
    for (int i = 0; i < o; i++) acc += 128'(signed'(abw[o-1][i])) * vhist[i][c];
    neg = acc < 0;
    m = neg ? -acc : acc;
    return sat_mag(neg, (m + 360) / 720);
  endfunction

  function automatic word_t path_delta(bit hneg, logic [WB-1:0] hmag, word_t v);
    logic [127:0] p;
    p = (128'(hmag) * magn(v) + (128'd1 << 31)) >> 32;
    return sat_mag(hneg != (v < 0), p);
  endfunction

  function automatic bit advance_path(op_t op, word_t f[8], output point_pair_t r);
    logic signed [63:0] rem;
    logic [63:0] m101;
    logic [WB-1:0] hmag;
    word_t vn, tgt[3], to_tick;
    bit fwd, last;
    int o;
    if (op == OP_START) begin
      for (int c = 0; c < 3; c++) pos[c] = f[c];
      now_t = f[3];
      order_q = 1;
      return 0;
    end
    fwd = f[7] > now_t;
    rem = fwd ? 64'(f[7]) - 64'(now_t) : 64'(now_t) - 64'(f[7]);
    m101 = 64'(step_max) + 64'(step_max) / 100;
    last = m101 > $unsigned(rem);
    hmag = last ? rem[WB-1:0] : WB'(step_max);
    for (int c = 0; c < 3; c++) begin
      r.f[c] = pos[c];
      r.f[3+c] = pos[c];
    end
    r.f[6] = now_t;
    r.f[7] = now_t;
    if (hmag == 0) begin
      r.st = ST_UNDERFLOW;
      return 1;
    end
    o = order_q;
    for (int c = 0; c < 3; c++) vhist[0][c] = f[4+c];
    for (int c = 0; c < 3; c++) begin
      vn = ab_velocity(o, c);
      tgt[c] = sat_add(pos[c], path_delta(!fwd, hmag, vn));
    end
    if (o < 5) o++;
    for (int i = o - 1; i > 0; i--)
      for (int c = 0; c < 3; c++) vhist[i][c] = vhist[i-1][c];
    order_q = o;
    to_tick = last ? f[7] : (fwd ? now_t + hmag : now_t - hmag);
    r.st = last ? ST_FINAL : ST_OK;
    for (int c = 0; c < 3; c++) begin
      r.f[3+c] = tgt[c];
      pos[c] = tgt[c];
    end
    r.f[7] = to_tick;
    now_t = to_tick;
    if (last && periodic) now_t = sat_add(now_t, 1);
    return 1;
  endfunction

  function automatic word_t rand_word();
    return word_t'({$urandom, $urandom});
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(7))
      0: return W_MAX;
      1: return W_MIN;
      2: return word_t'(signed'($urandom_range(2000)) - 1000);
      3, 4: return word_t'(signed'($urandom)) <<< $urandom_range(20);
      default: return rand_word();
    endcase
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  task automatic send_beat(op_t op, word_t f[8], bit known, status_t st);
    point_pair_t r;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    for (int i = 0; i < 8; i++) in_tdata[i*WB +: WB] <= f[i];
    do @(posedge clk); while (!in_tready);
    if (advance_path(op, f, r)) begin
      if (known) r.st = st;
      pending_pts.push_back(r);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic reg_write(logic [3:0] a, logic [63:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (a == ADDR_MAX_STEP) step_max = d[46:0];
    else if (a == ADDR_PERIODIC) periodic = d[0];
  endtask

  task automatic random_runs(int n_items);
    word_t f[8], end_t;
    logic signed [63:0] e;
    int sent, nsteps;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(19) == 0) begin
        for (int i = 0; i < 8; i++) f[i] = rand_word();
        send_beat(op_t'($urandom_range(1)), f, 0, ST_OK);
        sent++;
        continue;
      end
      if ($urandom_range(9) != 0) begin
        for (int i = 0; i < 8; i++) f[i] = rand_word();
        for (int i = 0; i < 4; i++) f[i] = pick_word();
        send_beat(OP_START, f, 0, ST_OK);
        sent++;
      end
      e = 64'(now_t) + ($urandom_range(1) ? 1 : -1) *
          (64'(step_max) * $urandom_range(0, 12) + $urandom_range(0, 3000));
      if ($urandom_range(15) == 0) e = 64'(pick_word());
      end_t = e > 64'(W_MAX) ? W_MAX : (e < 64'(W_MIN) ? W_MIN : e[WB-1:0]);
      nsteps = $urandom_range(1, 14);
      for (int s = 0; s < nsteps; s++) begin
        for (int i = 0; i < 8; i++) f[i] = rand_word();
        for (int i = 4; i < 7; i++) f[i] = pick_word();
        f[7] = end_t;
        send_beat(OP_STEP, f, 0, ST_OK);
        sent++;
      end
    end
  endtask

  // result checking
  always @(posedge clk) begin
    point_pair_t x;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pts.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        x = pending_pts.pop_front();
        if (out_tuser !== x.st) begin
          $error("status: expected %0d, got %0d", x.st, out_tuser);
          errors++;
        end
        for (int i = 0; i < 8; i++)
          if (out_tdata[i*WB +: WB] !== x.f[i]) begin
            $error("%s: expected %0d, got %0d",
                   i == 0 ? "from_x" : i == 1 ? "from_y" : i == 2 ? "from_z" :
                   i == 3 ? "to_x" : i == 4 ? "to_y" : i == 5 ? "to_z" :
                   i == 6 ? "from_tick" : "to_tick",
                   x.f[i], $signed(out_tdata[i*WB +: WB]));
            errors++;
          end
      end
    end
  end

  // receiver backpressure
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (STALL_LEN) @(posedge clk);
        hold_req = 0;
      end else if ($urandom_range(2) == 0) begin
        out_tready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("FAIL adams_bashforth_path_stepper");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    word_t f[8];
    logic [63:0] steps[5];
    bit pmodes[5];
    pos = '{0, 0, 0};
    now_t = 0;
    order_q = 1;
    step_max = MAX_STEP_RESET;
    periodic = 0;
    for (int i = 0; i < 5; i++) for (int c = 0; c < 3; c++) vhist[i][c] = 0;

    rows = '{
      '{OP_STEP, 1, 1, 1, 0, 1, ST_UNDERFLOW},
      '{OP_START, 0, 0, 0, 0, 0, ST_OK},
      '{OP_STEP, W_MAX, W_MIN, 0, 48'sd1 <<< 40, 1, ST_OK},
      '{OP_STEP, W_MIN, W_MAX, 1, 48'sd1 <<< 40, 1, ST_OK},
      '{OP_STEP, -1, 1, W_MAX, 48'sd1 <<< 40, 1, ST_OK},
      '{OP_STEP, W_MAX, W_MAX, W_MAX, 48'sd1 <<< 40, 1, ST_OK},
      '{OP_STEP, W_MIN, W_MIN, W_MIN, 48'sd1 <<< 40, 1, ST_OK},
      '{OP_STEP, 5, 6, 7, 48'sd1 <<< 40, 1, ST_OK},
      '{OP_START, W_MIN, W_MIN, W_MIN, 100, 0, ST_OK},
      '{OP_STEP, W_MIN, W_MIN, W_MIN, 100, 1, ST_UNDERFLOW},
      '{OP_STEP, W_MIN, W_MIN, W_MIN, 110, 1, ST_FINAL},
      '{OP_START, W_MAX, W_MAX, W_MAX, W_MAX, 0, ST_OK},
      '{OP_STEP, W_MAX, W_MAX, W_MAX, W_MIN, 1, ST_OK},
      '{OP_STEP, W_MIN, W_MIN, W_MIN, W_MIN, 1, ST_OK},
      '{OP_START, 0, 0, 0, 0, 0, ST_OK},
      '{OP_STEP, 1000, -1000, 7, -30000, 1, ST_FINAL},
      '{OP_STEP, 3, 2, 1, -30000, 1, ST_UNDERFLOW},
      '{OP_START, 0, 0, 0, 0, 0, ST_OK},
      '{OP_STEP, 9, 9, 9, 43379, 1, ST_OK},
      '{OP_STEP, 9, 9, 9, 43379, 1, ST_FINAL}
    };
    steps = '{MAX_STEP_RESET, 1, 64'(STEP_TOP), 64'(1) << 36, 4000};
    pmodes = '{0, 1, 0, 1, 1};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[k]) begin
      for (int i = 0; i < 8; i++) f[i] = 0;
      if (rows[k].op == OP_START) begin
        f[0] = rows[k].a; f[1] = rows[k].b; f[2] = rows[k].c; f[3] = rows[k].d;
      end else begin
        f[4] = rows[k].a; f[5] = rows[k].b; f[6] = rows[k].c; f[7] = rows[k].d;
      end
      send_beat(rows[k].op, f, rows[k].known, rows[k].st);
    end
    drain();

    for (int p = 0; p < 5; p++) begin
      reg_write(ADDR_MAX_STEP, steps[p]);
      reg_write(ADDR_PERIODIC, 64'(pmodes[p]));
      if (p == 1) hold_req = 1;
      random_runs(320);
      drain();
    end

    if (errors == 0) $display("PASS adams_bashforth_path_stepper");
    else $display("FAIL adams_bashforth_path_stepper");
    $finish;
  end

endmodule
